>>> hdl/wiolj_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wiolj_pkg: shared types and constants of the window interval overlap join
// Sizes of the reference store, operation codes, register indexes and the
// request and response structs that travel between the modules.
// ----------------------------------------------------------------------------
package wiolj_pkg;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned MAX_HITS    = 32;

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned HIT_W = $clog2(MAX_HITS + 1);

  localparam int unsigned COORD_W = 32;
  localparam int unsigned EXT_W   = 24;

  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [1:0] REG_LEFT_EXTEND  = 2'd0;
  localparam logic [1:0] REG_RIGHT_EXTEND = 2'd1;
  localparam logic [1:0] REG_MIRROR_MODE  = 2'd2;

  localparam logic [EXT_W-1:0] LEFT_EXTEND_RESET  = EXT_W'(1000);
  localparam logic [EXT_W-1:0] RIGHT_EXTEND_RESET = EXT_W'(1000);

  // Request to the shared adder pair: each lane computes a - b or a + b.
  typedef struct packed {
    logic [COORD_W-1:0] a0;
    logic [COORD_W-1:0] b0;
    logic               sub0;
    logic [COORD_W-1:0] a1;
    logic [COORD_W-1:0] b1;
    logic               sub1;
  } alu_req_t;

  // Bit COORD_W is the borrow of a subtraction or the carry of an addition.
  typedef struct packed {
    logic [COORD_W:0] r0;
    logic [COORD_W:0] r1;
  } alu_rsp_t;

  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [COORD_W-1:0] wr_start;
    logic [COORD_W-1:0] wr_stop;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
  } store_req_t;

endpackage

`default_nettype wire

>>> hdl/window_interval_overlap_join_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_interval_overlap_join_unit: sorted interval overlap join, top level
// Keeps a store of reference intervals and reports, for each query, every
// stored interval that overlaps the widened query window, up to the hit limit.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Restart and
// load beats never raise busy, so such beats may follow each other in
// consecutive cycles. A query raises busy until its last result beat has been
// shown. Results appear on hit, ref_index, rel_start, rel_stop, overflow and
// last for exactly one cycle each, marked by result_valid; the receiver
// cannot stall them, so it must take every beat in the cycle it appears.
// How long a query keeps busy high depends on the number of stored intervals
// the persistent scan pointer moves past, the number of hits and the number
// of examined intervals that end below the window. The walk stops on an
// interval that starts above the window, on the hit limit, or when the
// pointer reaches the end of the store. Query time is set by the single read
// port of the reference memory, which delivers one registered entry per read,
// and by the one pair of shared add/subtract lanes that forms the window
// edges, the ordering compares and the relative positions in turn. Each hit
// is held in a pending register until the next hit or the final beat, so
// that the final beat can carry last and overflow. The reference memory is
// not cleared by reset or by restart; only entries written since the last
// restart are ever read. Configuration registers sit on the APB port at byte
// addresses 0 (left extension), 4 (right extension) and 8 (mirror mode) and
// may only be written while busy is low.
// ----------------------------------------------------------------------------
module window_interval_overlap_join_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Command channel.
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        opcode,
  input  wire logic [wiolj_pkg::COORD_W-1:0]     interval_start,
  input  wire logic [wiolj_pkg::COORD_W-1:0]     interval_stop,
  // Result channel.
  output logic                                   result_valid,
  output logic                                   hit,
  output logic [wiolj_pkg::IDX_W-1:0]            ref_index,
  output logic signed [wiolj_pkg::COORD_W-1:0]   rel_start,
  output logic signed [wiolj_pkg::COORD_W-1:0]   rel_stop,
  output logic                                   overflow,
  output logic                                   last,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [3:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int unsigned W  = wiolj_pkg::COORD_W;
  localparam int unsigned EW = wiolj_pkg::EXT_W;

  logic [EW-1:0]         left_extend;
  logic [EW-1:0]         right_extend;
  logic                  mirror_mode;
  logic                  cfg_write;
  wiolj_pkg::alu_req_t   alu_req;
  wiolj_pkg::alu_rsp_t   alu_rsp;
  wiolj_pkg::store_req_t st_req;
  logic [W-1:0]          rd_start;
  logic [W-1:0]          rd_stop;
  logic [W-1:0]          rel_start_u;
  logic [W-1:0]          rel_stop_u;

  // The port never inserts wait states, so a write lands on the access beat.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_extend  <= wiolj_pkg::LEFT_EXTEND_RESET;
      right_extend <= wiolj_pkg::RIGHT_EXTEND_RESET;
      mirror_mode  <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        wiolj_pkg::REG_LEFT_EXTEND:  left_extend  <= pwdata[EW-1:0];
        wiolj_pkg::REG_RIGHT_EXTEND: right_extend <= pwdata[EW-1:0];
        wiolj_pkg::REG_MIRROR_MODE:  mirror_mode  <= pwdata[0];
        default: begin
          mirror_mode <= mirror_mode;
        end
      endcase
    end
  end

  // Register read-back; addresses past the register list read as zero.
  always_comb begin
    unique case (paddr[3:2])
      wiolj_pkg::REG_LEFT_EXTEND:  prdata = 32'(left_extend);
      wiolj_pkg::REG_RIGHT_EXTEND: prdata = 32'(right_extend);
      wiolj_pkg::REG_MIRROR_MODE:  prdata = 32'(mirror_mode);
      default:                     prdata = '0;
    endcase
  end

  wiolj_ref_store u_store (
    .clk      (clk),
    .req      (st_req),
    .rd_start (rd_start),
    .rd_stop  (rd_stop)
  );

  wiolj_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  wiolj_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .interval_start (interval_start),
    .interval_stop  (interval_stop),
    .left_extend    (left_extend),
    .right_extend   (right_extend),
    .mirror_mode    (mirror_mode),
    .alu_req        (alu_req),
    .alu_rsp        (alu_rsp),
    .st_req         (st_req),
    .rd_start       (rd_start),
    .rd_stop        (rd_stop),
    .result_valid   (result_valid),
    .hit            (hit),
    .ref_index      (ref_index),
    .rel_start      (rel_start_u),
    .rel_stop       (rel_stop_u),
    .overflow       (overflow),
    .last           (last)
  );

  // Relative positions wrap modulo 2^32 and are presented as two's complement.
  assign rel_start = signed'(rel_start_u);
  assign rel_stop  = signed'(rel_stop_u);

endmodule

`default_nettype wire

>>> hdl/wiolj_ref_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wiolj_ref_store: reference interval memory
// One write port and one read port; read data is registered and holds its
// value until the next read.
// ----------------------------------------------------------------------------
module wiolj_ref_store (
  input  wire logic                            clk,
  input  wire wiolj_pkg::store_req_t           req,
  output logic [wiolj_pkg::COORD_W-1:0]        rd_start,
  output logic [wiolj_pkg::COORD_W-1:0]        rd_stop
);

  logic [2*wiolj_pkg::COORD_W-1:0] mem [wiolj_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= {req.wr_start, req.wr_stop};
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      {rd_start, rd_stop} <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/wiolj_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wiolj_alu: shared adder pair
// Two 33-bit add/subtract lanes that the sequencer reuses for window edges,
// ordering compares and relative positions.
// ----------------------------------------------------------------------------
module wiolj_alu (
  input  wire wiolj_pkg::alu_req_t  req,
  output wiolj_pkg::alu_rsp_t       rsp
);

  always_comb begin
    if (req.sub0) begin
      rsp.r0 = {1'b0, req.a0} - {1'b0, req.b0};
    end else begin
      rsp.r0 = {1'b0, req.a0} + {1'b0, req.b0};
    end
    if (req.sub1) begin
      rsp.r1 = {1'b0, req.a1} - {1'b0, req.b1};
    end else begin
      rsp.r1 = {1'b0, req.a1} + {1'b0, req.b1};
    end
  end

endmodule

`default_nettype wire

>>> hdl/wiolj_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wiolj_ctrl: operation sequencer
// Takes restart, load and query beats, walks the store one entry at a time
// and drives the result beats through a one-deep pending hit register.
// ----------------------------------------------------------------------------
module wiolj_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          opcode,
  input  wire logic [wiolj_pkg::COORD_W-1:0]       interval_start,
  input  wire logic [wiolj_pkg::COORD_W-1:0]       interval_stop,
  input  wire logic [wiolj_pkg::EXT_W-1:0]         left_extend,
  input  wire logic [wiolj_pkg::EXT_W-1:0]         right_extend,
  input  wire logic                                mirror_mode,
  output wiolj_pkg::alu_req_t                      alu_req,
  input  wire wiolj_pkg::alu_rsp_t                 alu_rsp,
  output wiolj_pkg::store_req_t                    st_req,
  input  wire logic [wiolj_pkg::COORD_W-1:0]       rd_start,
  input  wire logic [wiolj_pkg::COORD_W-1:0]       rd_stop,
  output logic                                     result_valid,
  output logic                                     hit,
  output logic [wiolj_pkg::IDX_W-1:0]              ref_index,
  output logic [wiolj_pkg::COORD_W-1:0]            rel_start,
  output logic [wiolj_pkg::COORD_W-1:0]            rel_stop,
  output logic                                     overflow,
  output logic                                     last
);

  localparam int unsigned W  = wiolj_pkg::COORD_W;
  localparam int unsigned CW = wiolj_pkg::CNT_W;
  localparam int unsigned IW = wiolj_pkg::IDX_W;
  localparam int unsigned HW = wiolj_pkg::HIT_W;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_WIN      = 8'b0000_0010,
    ST_SKIP_RD  = 8'b0000_0100,
    ST_SKIP_CHK = 8'b0000_1000,
    ST_EXAM_RD  = 8'b0001_0000,
    ST_EXAM_CHK = 8'b0010_0000,
    ST_EXAM_REL = 8'b0100_0000,
    ST_FLUSH    = 8'b1000_0000
  } state_t;

  state_t          state;
  logic [CW-1:0]   ref_count;
  logic [CW-1:0]   scan_pointer;
  logic [CW-1:0]   idx;
  logic [HW-1:0]   hit_count;
  logic            more;
  logic [W-1:0]    q_start;
  logic [W-1:0]    q_stop;
  logic [W-1:0]    lo;
  logic [W-1:0]    hi;
  logic            pend_valid;
  logic [IW-1:0]   pend_index;
  logic [W-1:0]    pend_rel_start;
  logic [W-1:0]    pend_rel_stop;
  logic            accept;
  logic            store_full;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && (state == ST_IDLE);
  assign store_full = (ref_count >= CW'(wiolj_pkg::STORE_DEPTH));

  // Operand selection for the shared adder pair.
  always_comb begin
    alu_req = '0;
    unique case (state)
      ST_WIN: begin
        alu_req.a0   = q_start;
        alu_req.b0   = W'(left_extend);
        alu_req.sub0 = 1'b1;
        alu_req.a1   = q_stop;
        alu_req.b1   = W'(right_extend);
        alu_req.sub1 = 1'b0;
      end
      ST_SKIP_CHK: begin
        alu_req.a0   = rd_stop;
        alu_req.b0   = lo;
        alu_req.sub0 = 1'b1;
      end
      ST_EXAM_CHK: begin
        alu_req.a0   = hi;
        alu_req.b0   = rd_start;
        alu_req.sub0 = 1'b1;
        alu_req.a1   = rd_stop;
        alu_req.b1   = lo;
        alu_req.sub1 = 1'b1;
      end
      ST_EXAM_REL: begin
        alu_req.sub0 = 1'b1;
        alu_req.sub1 = 1'b1;
        if (mirror_mode) begin
          alu_req.a0 = hi;
          alu_req.b0 = rd_stop;
          alu_req.a1 = hi;
          alu_req.b1 = rd_start;
        end else begin
          alu_req.a0 = rd_start;
          alu_req.b0 = lo;
          alu_req.a1 = rd_stop;
          alu_req.b1 = lo;
        end
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    st_req          = '0;
    st_req.wr_en    = accept && (opcode == wiolj_pkg::OP_LOAD) && !store_full;
    st_req.wr_addr  = ref_count[IW-1:0];
    st_req.wr_start = interval_start;
    st_req.wr_stop  = interval_stop;
    if (state == ST_SKIP_RD) begin
      st_req.rd_en   = (scan_pointer < ref_count);
      st_req.rd_addr = scan_pointer[IW-1:0];
    end else if (state == ST_EXAM_RD) begin
      st_req.rd_en   = (idx < ref_count);
      st_req.rd_addr = idx[IW-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ref_count    <= '0;
      scan_pointer <= '0;
      idx          <= '0;
      hit_count    <= '0;
      more         <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (opcode)
              wiolj_pkg::OP_RESTART: begin
                ref_count    <= '0;
                scan_pointer <= '0;
              end
              wiolj_pkg::OP_LOAD: begin
                if (!store_full) begin
                  ref_count <= ref_count + CW'(1);
                end
              end
              wiolj_pkg::OP_QUERY: begin
                hit_count  <= '0;
                more       <= 1'b0;
                pend_valid <= 1'b0;
                state      <= ST_WIN;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_WIN: begin
          if (scan_pointer > ref_count) begin
            scan_pointer <= ref_count;
          end
          state <= ST_SKIP_RD;
        end
        ST_SKIP_RD: begin
          if (scan_pointer < ref_count) begin
            state <= ST_SKIP_CHK;
          end else begin
            state <= ST_FLUSH;
          end
        end
        ST_SKIP_CHK: begin
          if (alu_rsp.r0[W]) begin
            scan_pointer <= scan_pointer + CW'(1);
            state        <= ST_SKIP_RD;
          end else begin
            idx   <= scan_pointer;
            state <= ST_EXAM_CHK;
          end
        end
        ST_EXAM_RD: begin
          if (idx < ref_count) begin
            state <= ST_EXAM_CHK;
          end else begin
            state <= ST_FLUSH;
          end
        end
        ST_EXAM_CHK: begin
          priority if (alu_rsp.r0[W]) begin
            state <= ST_FLUSH;
          end else if (alu_rsp.r1[W]) begin
            idx   <= idx + CW'(1);
            state <= ST_EXAM_RD;
          end else if (hit_count >= HW'(wiolj_pkg::MAX_HITS)) begin
            more  <= 1'b1;
            state <= ST_FLUSH;
          end else begin
            state <= ST_EXAM_REL;
          end
        end
        ST_EXAM_REL: begin
          if (pend_valid) begin
            result_valid <= 1'b1;
          end
          pend_valid <= 1'b1;
          hit_count  <= hit_count + HW'(1);
          idx        <= idx + CW'(1);
          state      <= ST_EXAM_RD;
        end
        ST_FLUSH: begin
          result_valid <= 1'b1;
          pend_valid   <= 1'b0;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: query window, pending hit and the result beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_start <= interval_start;
      q_stop  <= interval_stop;
    end
    if (state == ST_WIN) begin
      lo <= alu_rsp.r0[W] ? '0 : alu_rsp.r0[W-1:0];
      hi <= alu_rsp.r1[W] ? '1 : alu_rsp.r1[W-1:0];
    end
    if (state == ST_EXAM_REL) begin
      hit            <= 1'b1;
      ref_index      <= pend_index;
      rel_start      <= pend_rel_start;
      rel_stop       <= pend_rel_stop;
      overflow       <= 1'b0;
      last           <= 1'b0;
      pend_index     <= idx[IW-1:0];
      pend_rel_start <= alu_rsp.r0[W-1:0];
      pend_rel_stop  <= alu_rsp.r1[W-1:0];
    end
    if (state == ST_FLUSH) begin
      last <= 1'b1;
      if (pend_valid) begin
        hit       <= 1'b1;
        ref_index <= pend_index;
        rel_start <= pend_rel_start;
        rel_stop  <= pend_rel_stop;
        overflow  <= more;
      end else begin
        hit       <= 1'b0;
        ref_index <= '0;
        rel_start <= '0;
        rel_stop  <= '0;
        overflow  <= 1'b0;
      end
    end
  end

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_WIN) |-> (scan_pointer <= ref_count))
    else $error("scan pointer ran past the stored interval count");

  a_hit_bound: assert property (@(posedge clk) disable iff (rst)
    hit_count <= HW'(wiolj_pkg::MAX_HITS))
    else $error("hit counter exceeded the hit limit");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> (state == ST_IDLE))
    else $error("final result beat while the query is still running");

  a_miss_final: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !hit) |-> last)
    else $error("miss result beat not marked final");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending hit left over after a query");

endmodule

`default_nettype wire
